FILE: rtl/m4m_pkg.sv
// ----------------------------------------------------------------------------
// m4m_pkg
// shared constants, types and codes of the 4x4 fixed-point matrix multiplier
// ----------------------------------------------------------------------------
package m4m_pkg;

  // matrix shape and number format
  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int CELLS     = DIM * DIM;
  localparam int DIM_W     = $clog2(DIM);
  localparam int ADDR_W    = $clog2(CELLS);

  // field widths of the stream items
  localparam int IDX_W     = 4;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 2;
  localparam int TDATA_W   = ((IDX_W + DATA_W + 7) / 8) * 8;
  localparam int PAD_W     = TDATA_W - IDX_W - DATA_W;

  // datapath widths: full product, shifted term, sum of DIM terms
  localparam int PROD_W    = 2 * DATA_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int SUM_W     = TERM_W + DIM_W;

  typedef logic [DIM_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam cnt_t  K_LAST   = cnt_t'(DIM - 1);
  localparam addr_t POS_LAST = addr_t'(CELLS - 1);

  // operation selector carried in the input tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // one multiply-accumulate step issued by the sequencer
  typedef struct packed {
    logic  valid;
    cnt_t  k;
    addr_t pos;
    addr_t a_addr;
    addr_t b_addr;
  } m4m_issue_t;

  // one finished product element
  typedef struct packed {
    addr_t                    index;
    logic signed [DATA_W-1:0] value;
    logic                     sat;
    logic                     last;
  } m4m_result_t;

endpackage

FILE: rtl/matrix4_multiply_core.sv
// ----------------------------------------------------------------------------
// matrix4_multiply_core - 4x4 signed Q16.16 matrix multiplier, column-major
// loads are accepted back to back while no compute run is issuing
// compute: one product item per element, in index order (one shared
//   multiplier, 4 k steps per element); a stalled result output holds the
//   steps; input ready again once the run has issued its last step
// reset clears both stores at once (valid bits) and the pipeline; no sweep
// ----------------------------------------------------------------------------
module matrix4_multiply_core (
  input  logic                         clk,
  input  logic                         rst,
  // input items
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [m4m_pkg::TDATA_W-1:0]  s_axis_tdata,  // element_index, element_value, pad
  input  logic [m4m_pkg::FUNC_W-1:0]   s_axis_tuser,  // func
  // result items
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [m4m_pkg::TDATA_W-1:0]  m_axis_tdata,  // result_index, result_value, pad
  output logic                         m_axis_tuser,  // saturated
  output logic                         m_axis_tlast
);

  logic                              busy;
  logic                              in_acc;
  logic                              start;
  logic                              we_a;
  logic                              we_b;
  logic                              in_range;
  logic                              adv;
  m4m_pkg::addr_t                    waddr;
  logic signed [m4m_pkg::DATA_W-1:0] wdata;
  logic signed [m4m_pkg::DATA_W-1:0] a_rd;
  logic signed [m4m_pkg::DATA_W-1:0] b_rd;
  m4m_pkg::m4m_issue_t               issue;
  m4m_pkg::m4m_result_t              result;
  logic [m4m_pkg::IDX_W-1:0]         element_index;

  // input decode
  assign s_axis_tready = !busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign element_index = s_axis_tdata[m4m_pkg::IDX_W-1:0];
  assign wdata         = s_axis_tdata[m4m_pkg::IDX_W +: m4m_pkg::DATA_W];
  assign in_range      = (32'(element_index) < m4m_pkg::CELLS);
  assign waddr         = m4m_pkg::addr_t'(element_index);
  assign we_a  = in_acc && in_range && (s_axis_tuser == m4m_pkg::FUNC_LOAD_A);
  assign we_b  = in_acc && in_range && (s_axis_tuser == m4m_pkg::FUNC_LOAD_B);
  assign start = in_acc && (s_axis_tuser == m4m_pkg::FUNC_COMPUTE);

  m4m_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .adv   (adv),
    .busy  (busy),
    .issue (issue)
  );

  m4m_store u_store_a (
    .clk   (clk),
    .rst   (rst),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .en    (adv),
    .raddr (issue.a_addr),
    .rdata (a_rd)
  );

  m4m_store u_store_b (
    .clk   (clk),
    .rst   (rst),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .en    (adv),
    .raddr (issue.b_addr),
    .rdata (b_rd)
  );

  m4m_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .a_rd      (a_rd),
    .b_rd      (b_rd),
    .adv       (adv),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .result    (result)
  );

  // output packing
  assign m_axis_tdata = {{m4m_pkg::PAD_W{1'b0}}, result.value,
                         m4m_pkg::IDX_W'(result.index)};
  assign m_axis_tuser = result.sat;
  assign m_axis_tlast = result.last;

  // no item is accepted while a compute run is issuing
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && !s_axis_tready)
    else $error("matrix4_multiply_core: ready while compute issuing");

endmodule

FILE: rtl/m4m_store.sv
// ----------------------------------------------------------------------------
// m4m_store
// one matrix store: single write port, registered read port, entries that
// were never written since reset read as zero
// ----------------------------------------------------------------------------
module m4m_store (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                we,
  input  m4m_pkg::addr_t                      waddr,
  input  logic signed [m4m_pkg::DATA_W-1:0]   wdata,
  input  logic                                en,
  input  m4m_pkg::addr_t                      raddr,
  output logic signed [m4m_pkg::DATA_W-1:0]   rdata
);

  logic signed [m4m_pkg::DATA_W-1:0] mem [m4m_pkg::CELLS];
  logic [m4m_pkg::CELLS-1:0]         valid;

  // storage array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // per-entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // registered read, held while the pipeline stalls
  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= valid[raddr] ? mem[raddr] : '0;
    end
  end

  // a written entry is marked valid on the following cycle
  a_write_marks: assert property (@(posedge clk) disable iff (rst)
    we |=> valid[$past(waddr)])
    else $error("m4m_store: written entry not marked valid");

endmodule

FILE: rtl/m4m_ctrl.sv
// ----------------------------------------------------------------------------
// m4m_ctrl
// sequencer: walks column, row and k over all product elements and issues
// one read of each store per step
// ----------------------------------------------------------------------------
module m4m_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                adv,
  output logic                busy,
  output m4m_pkg::m4m_issue_t issue
);

  m4m_pkg::state_t state, state_next;
  m4m_pkg::cnt_t   cnt_k, cnt_i, cnt_c;
  logic            step_last;

  assign step_last = (cnt_k == m4m_pkg::K_LAST) && (cnt_i == m4m_pkg::K_LAST) &&
                     (cnt_c == m4m_pkg::K_LAST);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      m4m_pkg::ST_IDLE: begin
        if (start) begin
          state_next = m4m_pkg::ST_RUN;
        end
      end
      m4m_pkg::ST_RUN: begin
        if (adv && step_last) begin
          state_next = m4m_pkg::ST_IDLE;
        end
      end
      default: state_next = m4m_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy         = 1'b0;
    issue.valid  = 1'b0;
    issue.k      = cnt_k;
    issue.pos    = m4m_pkg::addr_t'(cnt_c * m4m_pkg::DIM + cnt_i);
    issue.a_addr = m4m_pkg::addr_t'(cnt_k * m4m_pkg::DIM + cnt_i);
    issue.b_addr = m4m_pkg::addr_t'(cnt_c * m4m_pkg::DIM + cnt_k);
    case (state)
      m4m_pkg::ST_IDLE: begin
        busy        = 1'b0;
        issue.valid = 1'b0;
      end
      m4m_pkg::ST_RUN: begin
        busy        = 1'b1;
        issue.valid = 1'b1;
      end
      default: begin
        busy        = 1'b0;
        issue.valid = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m4m_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // k innermost, then row, then column
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_k <= '0;
      cnt_i <= '0;
      cnt_c <= '0;
    end else if (state == m4m_pkg::ST_IDLE) begin
      cnt_k <= '0;
      cnt_i <= '0;
      cnt_c <= '0;
    end else if (adv) begin
      if (cnt_k == m4m_pkg::K_LAST) begin
        cnt_k <= '0;
        if (cnt_i == m4m_pkg::K_LAST) begin
          cnt_i <= '0;
          cnt_c <= (cnt_c == m4m_pkg::K_LAST) ? '0 : cnt_c + 1'b1;
        end else begin
          cnt_i <= cnt_i + 1'b1;
        end
      end else begin
        cnt_k <= cnt_k + 1'b1;
      end
    end
  end

  // a run starts at the first element with k at zero
  a_run_starts_clean: assert property (@(posedge clk) disable iff (rst)
    state == m4m_pkg::ST_RUN && $past(state) == m4m_pkg::ST_IDLE |->
      cnt_k == '0 && cnt_i == '0 && cnt_c == '0)
    else $error("m4m_ctrl: run did not start at element zero");

  // a stalled step keeps its addresses
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    issue.valid && !adv |=> issue.valid && $stable(issue.a_addr) &&
      $stable(issue.b_addr))
    else $error("m4m_ctrl: addresses moved during stall");

  // all k steps of one element are issued in a row, before the next element
  a_element_whole: assert property (@(posedge clk) disable iff (rst)
    issue.valid && adv && issue.k != m4m_pkg::K_LAST |=>
      issue.valid && issue.pos == $past(issue.pos))
    else $error("m4m_ctrl: element left before its last k step");

endmodule

FILE: rtl/m4m_mac.sv
// ----------------------------------------------------------------------------
// m4m_mac
// multiply-accumulate pipeline: tag stage aligned with the store reads,
// product register, shifted accumulate with saturation into the output item
// ----------------------------------------------------------------------------
module m4m_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  m4m_pkg::m4m_issue_t                 issue,
  input  logic signed [m4m_pkg::DATA_W-1:0]   a_rd,
  input  logic signed [m4m_pkg::DATA_W-1:0]   b_rd,
  output logic                                adv,
  output logic                                out_valid,
  input  logic                                out_ready,
  output m4m_pkg::m4m_result_t                result
);

  // stage 1 tags, aligned with read data
  logic                              v1;
  m4m_pkg::cnt_t                     k1;
  m4m_pkg::addr_t                    pos1;
  // stage 2: product
  logic                              v2;
  m4m_pkg::cnt_t                     k2;
  m4m_pkg::addr_t                    pos2;
  logic signed [m4m_pkg::PROD_W-1:0] prod;
  // accumulate
  logic signed [m4m_pkg::SUM_W-1:0]  acc;
  logic signed [m4m_pkg::TERM_W-1:0] term;
  logic signed [m4m_pkg::SUM_W-1:0]  base;
  logic signed [m4m_pkg::SUM_W-1:0]  sum;
  logic                              ovf;
  logic                              fin;

  // the final step of an element may not overwrite an untaken item
  assign fin = v2 && (k2 == m4m_pkg::K_LAST);
  assign adv = !(fin && out_valid && !out_ready);

  // tag stage and product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= issue.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1   <= issue.k;
      pos1 <= issue.pos;
      k2   <= k1;
      pos2 <= pos1;
      prod <= m4m_pkg::PROD_W'(a_rd) * m4m_pkg::PROD_W'(b_rd);
    end
  end

  // arithmetic shift is the upper bits of the product
  assign term = prod[m4m_pkg::PROD_W-1:m4m_pkg::FRAC_BITS];
  assign base = (k2 == '0) ? '0 : acc;
  assign sum  = base + {{(m4m_pkg::SUM_W - m4m_pkg::TERM_W){term[m4m_pkg::TERM_W-1]}}, term};

  // overflow when the bits above the 32-bit sign do not all agree
  assign ovf = !((&sum[m4m_pkg::SUM_W-1:m4m_pkg::DATA_W-1]) ||
                 (~|sum[m4m_pkg::SUM_W-1:m4m_pkg::DATA_W-1]));

  always_ff @(posedge clk) begin
    if (adv && v2 && !fin) begin
      acc <= sum;
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if (adv && fin) begin
      result.index <= pos2;
      result.sat   <= ovf;
      result.last  <= (pos2 == m4m_pkg::POS_LAST);
      if (!ovf) begin
        result.value <= sum[m4m_pkg::DATA_W-1:0];
      end else if (sum[m4m_pkg::SUM_W-1]) begin
        result.value <= {1'b1, {(m4m_pkg::DATA_W-1){1'b0}}};
      end else begin
        result.value <= {1'b0, {(m4m_pkg::DATA_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a clamped item holds one of the two range limits
  a_sat_limits: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.sat |->
      result.value == {1'b0, {(m4m_pkg::DATA_W-1){1'b1}}} ||
      result.value == {1'b1, {(m4m_pkg::DATA_W-1){1'b0}}})
    else $error("m4m_mac: saturated item not at a limit");

  // while stalled the product stage does not move
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(prod) && $stable(k2) && $stable(pos2))
    else $error("m4m_mac: pipeline moved during stall");

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench of matrix4_multiply_core
// loads random and corner-case Q16.16 elements into both matrix stores and
// runs compute items; product items are checked against typed expectations
// or a behavioral product of the testbench's own copy of the stores, under
// several idle and backpressure patterns on both streams
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam logic [m4m_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic signed [63:0] SUM_MAX     = 64'sd2147483647;
  localparam logic signed [63:0] SUM_MIN     = -64'sd2147483648;
  localparam int                 DRAIN_CYC   = 80;
  localparam int                 HOLD_CYC    = 400;
  localparam int                 RAND_ITEMS  = 200;

  logic                         clk;
  logic                         rst;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [m4m_pkg::TDATA_W-1:0]  s_axis_tdata;   // element_index, element_value, pad
  logic [m4m_pkg::FUNC_W-1:0]   s_axis_tuser;   // func
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [m4m_pkg::TDATA_W-1:0]  m_axis_tdata;   // result_index, result_value, pad
  logic                         m_axis_tuser;   // saturated
  logic                         m_axis_tlast;

  // one directed stimulus row; typed rows carry the value of element 0,
  // all other product elements are zero for them
  typedef struct {
    logic [m4m_pkg::FUNC_W-1:0] func;
    logic [m4m_pkg::IDX_W-1:0]  idx;
    logic [m4m_pkg::DATA_W-1:0] val;
    bit                         typed;
    logic [m4m_pkg::DATA_W-1:0] t_val;
    bit                         t_sat;
  } dir_row_t;

  dir_row_t                          dir_rows[$];
  m4m_pkg::m4m_result_t              product_q[$];
  logic signed [m4m_pkg::DATA_W-1:0] store_a [m4m_pkg::CELLS];
  logic signed [m4m_pkg::DATA_W-1:0] store_b [m4m_pkg::CELLS];

  int                          err_cnt;
  int                          send_pct;
  int                          recv_pct;
  int                          hold_left;
  bit                          typed_on;
  logic [m4m_pkg::DATA_W-1:0]  typed_val;
  bit                          typed_sat;

  // monitor temporaries
  logic [m4m_pkg::IDX_W-1:0]   mon_idx;
  logic [m4m_pkg::DATA_W-1:0]  mon_val;
  m4m_pkg::m4m_result_t        mon_exp;

  matrix4_multiply_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock, 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // full product of the two stores, pushed in index order
  function automatic void predict_product();
    logic signed [63:0]   a_ext;
    logic signed [63:0]   b_ext;
    logic signed [63:0]   acc;
    m4m_pkg::m4m_result_t e;
    int                   pos;
    for (int c = 0; c < m4m_pkg::DIM; c++) begin
      for (int i = 0; i < m4m_pkg::DIM; i++) begin
        acc = '0;
        pos = c * m4m_pkg::DIM + i;
        for (int k = 0; k < m4m_pkg::DIM; k++) begin
          a_ext = store_a[k * m4m_pkg::DIM + i];
          b_ext = store_b[c * m4m_pkg::DIM + k];
          acc   = acc + ((a_ext * b_ext) >>> m4m_pkg::FRAC_BITS);
        end
        e.index = m4m_pkg::addr_t'(pos);
        e.last  = (pos == m4m_pkg::CELLS - 1);
        if (acc > SUM_MAX) begin
          e.value = SUM_MAX[m4m_pkg::DATA_W-1:0];
          e.sat   = 1'b1;
        end else if (acc < SUM_MIN) begin
          e.value = SUM_MIN[m4m_pkg::DATA_W-1:0];
          e.sat   = 1'b1;
        end else begin
          e.value = acc[m4m_pkg::DATA_W-1:0];
          e.sat   = 1'b0;
        end
        product_q.push_back(e);
      end
    end
  endfunction

  // typed expectation: element 0 as given, the rest zero
  function automatic void push_typed_product();
    m4m_pkg::m4m_result_t e;
    for (int n = 0; n < m4m_pkg::CELLS; n++) begin
      e.index = m4m_pkg::addr_t'(n);
      e.value = (n == 0) ? typed_val : '0;
      e.sat   = (n == 0) ? typed_sat : 1'b0;
      e.last  = (n == m4m_pkg::CELLS - 1);
      product_q.push_back(e);
    end
  endfunction

  // mixed value classes: full range, small reals, corner values, +/-1.0 and zero
  function automatic logic [m4m_pkg::DATA_W-1:0] rand_value();
    logic [m4m_pkg::DATA_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = m4m_pkg::DATA_W'($urandom_range(0, (1 << 19) - 1)) - 32'h0004_0000;
      7: begin
        case ($urandom_range(4))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'hFFFF_FFFF;
          3:       v = 32'h0000_0001;
          default: v = 32'h0001_0000;
        endcase
      end
      8:       v = $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic void add_row(logic [m4m_pkg::FUNC_W-1:0] f,
                                  logic [m4m_pkg::IDX_W-1:0] i,
                                  logic [m4m_pkg::DATA_W-1:0] v, bit t = 0,
                                  logic [m4m_pkg::DATA_W-1:0] tv = '0, bit ts = 0);
    dir_row_t r;
    r.func  = f;
    r.idx   = i;
    r.val   = v;
    r.typed = t;
    r.t_val = tv;
    r.t_sat = ts;
    dir_rows.push_back(r);
  endfunction

  // drive one item after a random gap and hold it until accepted
  task automatic send_item(logic [m4m_pkg::FUNC_W-1:0] f, logic [m4m_pkg::IDX_W-1:0] i,
                           logic [m4m_pkg::DATA_W-1:0] v);
    int gap;
    gap = 0;
    if (send_pct > 0) begin
      while ($urandom_range(99) < send_pct) gap++;
    end
    @(negedge clk);
    while (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      gap--;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {{m4m_pkg::PAD_W{1'b0}}, v, i};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // pause the sender until every expected product item has come
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
  endtask

  // random load burst ended by a compute
  task automatic send_burst(ref int cnt);
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      send_item($urandom_range(1) ? m4m_pkg::FUNC_LOAD_B : m4m_pkg::FUNC_LOAD_A,
                m4m_pkg::IDX_W'($urandom_range(m4m_pkg::CELLS - 1)), rand_value());
      cnt++;
    end
    send_item(m4m_pkg::FUNC_COMPUTE, m4m_pkg::IDX_W'($urandom), $urandom);
    cnt++;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (recv_pct == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  // monitor: track the stores and check product items
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        mon_idx = s_axis_tdata[m4m_pkg::IDX_W-1:0];
        mon_val = s_axis_tdata[m4m_pkg::IDX_W +: m4m_pkg::DATA_W];
        case (s_axis_tuser)
          m4m_pkg::FUNC_LOAD_A: begin
            if (int'(mon_idx) < m4m_pkg::CELLS) store_a[mon_idx] = mon_val;
          end
          m4m_pkg::FUNC_LOAD_B: begin
            if (int'(mon_idx) < m4m_pkg::CELLS) store_b[mon_idx] = mon_val;
          end
          m4m_pkg::FUNC_COMPUTE: begin
            if (typed_on) push_typed_product();
            else predict_product();
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (product_q.size() == 0) begin
          $error("product item with none expected: index %0d value %h",
                 m_axis_tdata[m4m_pkg::IDX_W-1:0],
                 m_axis_tdata[m4m_pkg::IDX_W +: m4m_pkg::DATA_W]);
          err_cnt++;
        end else begin
          mon_exp = product_q.pop_front();
          if (m_axis_tdata[m4m_pkg::IDX_W-1:0] !== mon_exp.index) begin
            $error("result_index expected %0d actual %0d",
                   mon_exp.index, m_axis_tdata[m4m_pkg::IDX_W-1:0]);
            err_cnt++;
          end
          if (m_axis_tdata[m4m_pkg::IDX_W +: m4m_pkg::DATA_W] !== mon_exp.value) begin
            $error("result_value expected %h actual %h",
                   mon_exp.value, m_axis_tdata[m4m_pkg::IDX_W +: m4m_pkg::DATA_W]);
            err_cnt++;
          end
          if (m_axis_tuser !== mon_exp.sat) begin
            $error("saturated expected %0b actual %0b", mon_exp.sat, m_axis_tuser);
            err_cnt++;
          end
          if (m_axis_tlast !== mon_exp.last) begin
            $error("last expected %0b actual %0b", mon_exp.last, m_axis_tlast);
            err_cnt++;
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("matrix4_multiply_core verification failed");
    $finish;
  end

  // main sequence
  initial begin
    int cnt;
    int send_pcts [4];
    int recv_pcts [4];
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = m4m_pkg::FUNC_LOAD_A;
    m_axis_tready = 1'b0;
    err_cnt       = 0;
    send_pct      = 0;
    recv_pct      = 0;
    hold_left     = 0;
    typed_on      = 0;
    typed_val     = '0;
    typed_sat     = 0;
    send_pcts     = '{0, 77, 0, 6};
    recv_pcts     = '{0, 0, 77, 6};
    for (int n = 0; n < m4m_pkg::CELLS; n++) begin
      store_a[n] = '0;
      store_b[n] = '0;
    end

    // directed rows; only element 0 is nonzero while typed rows run
    add_row(m4m_pkg::FUNC_COMPUTE, 4'd0, 32'h0, 1, 32'h0, 0);
    add_row(m4m_pkg::FUNC_LOAD_A,  4'd0, 32'h7FFF_FFFF);
    add_row(m4m_pkg::FUNC_LOAD_B,  4'd0, 32'h7FFF_FFFF);
    add_row(m4m_pkg::FUNC_COMPUTE, 4'd0, 32'h0, 1, 32'h7FFF_FFFF, 1);
    add_row(m4m_pkg::FUNC_LOAD_B,  4'd0, 32'h8000_0000);
    add_row(m4m_pkg::FUNC_COMPUTE, 4'd0, 32'h0, 1, 32'h8000_0000, 1);
    add_row(m4m_pkg::FUNC_LOAD_A,  4'd0, 32'h8000_0000);
    add_row(m4m_pkg::FUNC_COMPUTE, 4'd0, 32'h0, 1, 32'h7FFF_FFFF, 1);
    add_row(m4m_pkg::FUNC_LOAD_A,  4'd0, 32'h0001_0000);
    add_row(m4m_pkg::FUNC_LOAD_B,  4'd0, 32'hFFFF_FFFF);
    // 1.0 times the smallest negative step rounds down to -1
    add_row(m4m_pkg::FUNC_COMPUTE, 4'd0, 32'h0, 1, 32'hFFFF_FFFF, 0);
    add_row(m4m_pkg::FUNC_LOAD_A,  4'd0, 32'h0000_0001);
    add_row(m4m_pkg::FUNC_LOAD_B,  4'd0, 32'h0000_0001);
    add_row(m4m_pkg::FUNC_COMPUTE, 4'd0, 32'h0, 1, 32'h0, 0);
    // unused code must not touch the stores
    add_row(FUNC_UNUSED,           4'd0, 32'h1234_5678);
    // fields of a compute are ignored
    add_row(m4m_pkg::FUNC_COMPUTE, 4'd15, 32'hFFFF_FFFF, 1, 32'h0, 0);
    add_row(m4m_pkg::FUNC_LOAD_A,  4'd15, 32'h0002_0000);
    add_row(m4m_pkg::FUNC_LOAD_B,  4'd15, 32'hFFFF_8000);
    add_row(m4m_pkg::FUNC_LOAD_A,  4'd5,  32'h0001_0000);
    add_row(m4m_pkg::FUNC_LOAD_B,  4'd5,  32'h7FFF_FFFF);
    add_row(m4m_pkg::FUNC_LOAD_A,  4'd10, 32'h8000_0000);
    add_row(m4m_pkg::FUNC_LOAD_B,  4'd10, 32'h8000_0000);
    add_row(m4m_pkg::FUNC_COMPUTE, 4'd7,  32'h5555_AAAA);
    add_row(m4m_pkg::FUNC_LOAD_A,  4'd3,  32'hFFFF_FFFF);
    add_row(m4m_pkg::FUNC_COMPUTE, 4'd0,  32'h0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part; the typed flags change after the monitor saw the accept
    foreach (dir_rows[r]) begin
      typed_on  <= dir_rows[r].typed;
      typed_val <= dir_rows[r].t_val;
      typed_sat <= dir_rows[r].t_sat;
      send_item(dir_rows[r].func, dir_rows[r].idx, dir_rows[r].val);
    end
    wait_drained();
    typed_on <= 0;

    // random part, one idle pattern per phase
    cnt = 0;
    for (int ph = 0; ph < 4; ph++) begin
      send_pct = send_pcts[ph];
      recv_pct = recv_pcts[ph];
      // long receiver hold-off while computes keep coming
      if (ph == 2) begin
        hold_left = HOLD_CYC;
        repeat (3) send_burst(cnt);
        wait_drained();
      end
      while (cnt < (RAND_ITEMS * (ph + 1)) / 4) begin
        case ($urandom_range(19))
          0, 1: send_item(FUNC_UNUSED, m4m_pkg::IDX_W'($urandom), $urandom);
          2, 3: begin
            send_item(m4m_pkg::FUNC_W'($urandom_range(3)), m4m_pkg::IDX_W'($urandom),
                      rand_value());
            cnt++;
          end
          default: send_burst(cnt);
        endcase
      end
      wait_drained();
    end

    // settle and report
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("matrix4_multiply_core verification clean");
    end else begin
      $display("matrix4_multiply_core verification failed");
    end
    $finish;
  end

endmodule
